[design/sensor_frame_crc_checker_top_defines.svh]
// ----------------------------------------------------------------------------
// Sensor frame CRC checker assertion macros
// Shared assertion helpers for the checker RTL. The checks are compiled
// out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECKER_TOP_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is skipped while reset is high.
`define SFCC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SFCC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFCC_ASSERT(name, clk, rst, prop, msg)
`define SFCC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[design/sfcc_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Types, codes and helper functions shared by the checker modules.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH  = 2'd1;

  localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h03;
  localparam logic [7:0] EXPECTED_LENGTH_RESET  = 8'h04;

  // CRC-16/Modbus constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions inside a frame; IDLE means no frame is open.
  localparam logic [3:0] POS_COMMAND  = 4'd0;
  localparam logic [3:0] POS_LENGTH   = 4'd1;
  localparam logic [3:0] POS_HUM_HI   = 4'd2;
  localparam logic [3:0] POS_HUM_LO   = 4'd3;
  localparam logic [3:0] POS_TEMP_HI  = 4'd4;
  localparam logic [3:0] POS_TEMP_LO  = 4'd5;
  localparam logic [3:0] POS_CRC_LO   = 4'd6;
  localparam logic [3:0] POS_CRC_HI   = 4'd7;
  localparam logic [3:0] POS_IDLE     = 4'd8;

  // Result status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC     = 2'd2;
  localparam logic [1:0] STATUS_BAD_COMMAND = 2'd3;

  typedef struct packed {
    logic               frame_ok;
    logic [1:0]         status;
    logic signed [15:0] temperature_tenths;
    logic signed [15:0] humidity_tenths;
  } result_t;

  // One byte of CRC-16/Modbus, unrolled over eight bit steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Sign-magnitude word to two's complement; minus zero gives zero.
  function automatic logic signed [15:0] sm_to_twos(input logic [15:0] word);
    logic [15:0] mag;
    mag = {1'b0, word[14:0]};
    if (word[15]) begin
      return -$signed(mag);
    end
    return $signed(mag);
  endfunction

endpackage

[design/sfcc_frame_parser.sv]
// ----------------------------------------------------------------------------
// Sensor frame parser
// Tracks the byte position, runs the CRC over the header and payload bytes,
// captures the fields and builds the result when the last byte arrives.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_checker_top_defines.svh"

module sfcc_frame_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  logic [7:0]            expected_command,
  input  logic [7:0]            expected_length,
  input  logic                  out_hold,
  output logic                  res_valid,
  output sfcc_pkg::result_t     res
);
  import sfcc_pkg::*;

  logic [3:0]  pos;
  logic [3:0]  pos_next;
  logic [15:0] crc;
  logic [15:0] crc_base;
  logic [7:0]  command_seen;
  logic [7:0]  length_seen;
  logic [15:0] humidity_raw;
  logic [15:0] temperature_raw;
  logic [7:0]  crc_low_received;
  logic [3:0]  eff_pos;
  logic        active;
  logic        accept;
  logic [15:0] rx_crc;
  logic [1:0]  status;

  // The last byte of a frame needs the result register; other bytes do not.
  assign in_stall = out_hold && (pos == POS_CRC_HI);
  assign accept   = in_valid && !in_stall;

  // A start flag always opens a new frame at byte zero.
  assign eff_pos  = frame_start ? POS_COMMAND : pos;
  assign active   = frame_start || (pos != POS_IDLE);
  assign crc_base = frame_start ? CRC_INIT : crc;

  always_comb begin
    if (eff_pos == POS_CRC_HI) begin
      pos_next = POS_IDLE;
    end else begin
      pos_next = eff_pos + 4'd1;
    end
  end

  // Position and CRC state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
      crc <= CRC_INIT;
    end else if (accept && active) begin
      pos <= pos_next;
      if (eff_pos < POS_CRC_LO) begin
        crc <= crc16_byte(crc_base, rx_byte);
      end else begin
        crc <= crc_base;
      end
    end
  end

  // Field capture.
  always_ff @(posedge clk) begin
    if (accept && active) begin
      case (eff_pos)
        POS_COMMAND: command_seen          <= rx_byte;
        POS_LENGTH:  length_seen           <= rx_byte;
        POS_HUM_HI:  humidity_raw[15:8]    <= rx_byte;
        POS_HUM_LO:  humidity_raw[7:0]     <= rx_byte;
        POS_TEMP_HI: temperature_raw[15:8] <= rx_byte;
        POS_TEMP_LO: temperature_raw[7:0]  <= rx_byte;
        POS_CRC_LO:  crc_low_received      <= rx_byte;
        default: begin
        end
      endcase
    end
  end

  // Checks in priority order: length, then CRC, then command.
  assign rx_crc = {rx_byte, crc_low_received};

  always_comb begin
    if (length_seen != expected_length) begin
      status = STATUS_BAD_LENGTH;
    end else if (rx_crc != crc) begin
      status = STATUS_BAD_CRC;
    end else if (command_seen != expected_command) begin
      status = STATUS_BAD_COMMAND;
    end else begin
      status = STATUS_OK;
    end
  end

  assign res_valid = accept && active && (eff_pos == POS_CRC_HI);

  always_comb begin
    res.frame_ok = (status == STATUS_OK);
    res.status   = status;
    if (status == STATUS_OK) begin
      res.temperature_tenths = sm_to_twos(temperature_raw);
      res.humidity_tenths    = sm_to_twos(humidity_raw);
    end else begin
      res.temperature_tenths = 16'sd0;
      res.humidity_tenths    = 16'sd0;
    end
  end

  `SFCC_ASSERT_ALWAYS(a_pos_range, clk, rst || (pos <= POS_IDLE), "byte position out of range")
  `SFCC_ASSERT(a_idle_after_result, clk, rst, res_valid |=> pos == POS_IDLE,
               "frame not closed after its result")
  `SFCC_ASSERT(a_failed_values_zero, clk, rst,
               (res_valid && !res.frame_ok) |->
               (res.temperature_tenths == 16'sd0 && res.humidity_tenths == 16'sd0),
               "failed frame carries nonzero values")

endmodule

[design/sfcc_result_stage.sv]
// ----------------------------------------------------------------------------
// Sensor frame result stage
// Output register that holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_checker_top_defines.svh"

module sfcc_result_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  sfcc_pkg::result_t  res,
  output logic               out_hold,
  output logic               out_valid,
  input  logic               out_stall,
  output sfcc_pkg::result_t  out_res
);
  import sfcc_pkg::*;

  logic load;

  assign out_hold = out_valid && out_stall;
  assign load     = res_valid;

  // Valid flag of the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the output word.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  `SFCC_ASSERT(a_no_overwrite, clk, rst, out_hold |-> !load,
               "result overwrites a word still waiting")
  `SFCC_ASSERT(a_load_shows, clk, rst, load |=> out_valid, "loaded result not shown")
  `SFCC_ASSERT(a_taken_clears, clk, rst, (out_valid && !out_stall && !load) |=> !out_valid,
               "taken word still shown")

endmodule

[design/sensor_frame_crc_checker_top.sv]
// Latency: a result word is shown the cycle after the last frame byte is taken.
// Throughput: one byte per cycle; only the last byte of a frame waits while
// the previous result is still held in the output register.
// Reset: synchronous, active high; the frame tracker goes idle, the CRC is
// preset and the expected command and length return to 3 and 4.
// ----------------------------------------------------------------------------
// Sensor frame CRC checker
// Checks CRC-16/Modbus framed sensor replies and decodes the readings.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_ok,
  output logic [1:0]                       status,
  output logic signed [15:0]               temperature_tenths,
  output logic signed [15:0]               humidity_tenths,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);
  import sfcc_pkg::*;

  logic [7:0] expected_command;
  logic [7:0] expected_length;
  logic       out_hold;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= EXPECTED_COMMAND_RESET;
      expected_length  <= EXPECTED_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_COMMAND: expected_command <= cfg_data;
        CFG_EXPECTED_LENGTH:  expected_length  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfcc_frame_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .frame_start      (frame_start),
    .expected_command (expected_command),
    .expected_length  (expected_length),
    .out_hold         (out_hold),
    .res_valid        (res_valid),
    .res              (res)
  );

  sfcc_result_stage u_result (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_hold  (out_hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign frame_ok           = out_res.frame_ok;
  assign status             = out_res.status;
  assign temperature_tenths = out_res.temperature_tenths;
  assign humidity_tenths    = out_res.humidity_tenths;

endmodule
